// ===== rtl/gcbs_pkg.sv =====
// gcbs_pkg: widths, codes and shared types of the ghost cell boundary source.
// Used by the channel interfaces, gcbs_lin_index and ghost_cell_boundary_source.
`timescale 1ns / 1ps
`default_nettype none

package gcbs_pkg;

  localparam int MAX_EXTENT = 1024;
  localparam int MAX_GHOST  = 16;

  // fixed field widths
  localparam int AXIS_W  = 2;
  localparam int LAYER_W = 4;
  localparam int COORD_W = 10;
  localparam int KIND_W  = 3;
  localparam int IDX_W   = 30;
  localparam int EXT_REG_W = 11;
  localparam int GH_REG_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // derived widths
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int GH_W  = $clog2(MAX_GHOST + 1);
  localparam int AW0   = (EXT_W > GH_W + 1) ? EXT_W : GH_W + 1;
  localparam int AW1   = (AW0 > COORD_W) ? AW0 : COORD_W;
  localparam int AW    = ((AW1 > LAYER_W) ? AW1 : LAYER_W) + 1;
  localparam int YP_W  = 2 * EXT_W;
  localparam int ZP_W  = 3 * EXT_W;
  localparam int SUM_W = ZP_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_Z  = 3'd5;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // boundary kinds
  localparam logic [KIND_W-1:0] KIND_REFLECT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OUTFLOW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INFLOW   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 3'd3;

  typedef struct packed {
    logic negate;
    logic use_inflow;
    logic fault;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/gcbs_if.sv =====
// gcbs channel interfaces: request, result and configuration write channels.
// Depends on gcbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gcbs_in_if;
  logic                              valid;
  logic                              ready;
  logic [gcbs_pkg::AXIS_W-1:0]       axis;
  logic                              side;
  logic [gcbs_pkg::LAYER_W-1:0]      layer;
  logic [gcbs_pkg::COORD_W-1:0]      coord_a;
  logic [gcbs_pkg::COORD_W-1:0]      coord_b;
  logic [gcbs_pkg::KIND_W-1:0]       boundary_kind;
  logic                              normal_velocity;

  modport source (output valid, axis, side, layer, coord_a, coord_b, boundary_kind,
                  normal_velocity, input ready);
  modport sink   (input valid, axis, side, layer, coord_a, coord_b, boundary_kind,
                  normal_velocity, output ready);
endinterface

interface gcbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcbs_pkg::IDX_W-1:0]    target_index;
  logic [gcbs_pkg::IDX_W-1:0]    source_index;
  logic                          negate;
  logic                          use_inflow;
  logic                          fault;

  modport source (output valid, target_index, source_index, negate, use_inflow, fault,
                  input ready);
  modport sink   (input valid, target_index, source_index, negate, use_inflow, fault,
                  output ready);
endinterface

interface gcbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gcbs_pkg::CFG_IDX_W-1:0]   index;
  logic [gcbs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gcbs_lin_index.sv =====
// gcbs_lin_index: three-stage pipeline for x + y*ext_x + z*ext_x*ext_y, mod 2^IDX_W.
// Depends on gcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcbs_lin_index (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [gcbs_pkg::EXT_W-1:0]   x_i,
  input  wire logic [gcbs_pkg::EXT_W-1:0]   y_i,
  input  wire logic [gcbs_pkg::EXT_W-1:0]   z_i,
  input  wire logic [gcbs_pkg::EXT_W-1:0]   ext_x_i,
  input  wire logic [gcbs_pkg::EXT_W-1:0]   ext_y_i,
  output logic      [gcbs_pkg::IDX_W-1:0]   idx_o
);

  logic [gcbs_pkg::EXT_W-1:0] x_a_q, z_a_q;
  logic [gcbs_pkg::YP_W-1:0]  yp_a_q, plane_a_q;
  logic [gcbs_pkg::YP_W:0]    xy_b_q;
  logic [gcbs_pkg::ZP_W-1:0]  zp_b_q;
  logic [gcbs_pkg::SUM_W-1:0] sum_c_d;
  logic [gcbs_pkg::IDX_W-1:0] idx_c_q;

  // stage A: row offset and plane size
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_a_q     <= x_i;
      z_a_q     <= z_i;
      yp_a_q    <= gcbs_pkg::YP_W'(y_i) * gcbs_pkg::YP_W'(ext_x_i);
      plane_a_q <= gcbs_pkg::YP_W'(ext_x_i) * gcbs_pkg::YP_W'(ext_y_i);
    end
  end

  // stage B: plane offset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xy_b_q <= (gcbs_pkg::YP_W + 1)'(x_a_q) + (gcbs_pkg::YP_W + 1)'(yp_a_q);
      zp_b_q <= gcbs_pkg::ZP_W'(z_a_q) * gcbs_pkg::ZP_W'(plane_a_q);
    end
  end

  // stage C: final sum
  assign sum_c_d = gcbs_pkg::SUM_W'(xy_b_q) + gcbs_pkg::SUM_W'(zp_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_c_q <= gcbs_pkg::IDX_W'(sum_c_d);
    end
  end

  assign idx_o = idx_c_q;

endmodule

`default_nettype wire

// ===== rtl/ghost_cell_boundary_source.sv =====
// ghost_cell_boundary_source: top level, config registers, decode stage and pipeline control.
// Depends on gcbs_pkg, gcbs_if and gcbs_lin_index.
`timescale 1ns / 1ps
`default_nettype none

// One beat in, one beat out per ghost cell, one beat per cycle sustained while output ready
// holds. The pipeline is a decode stage (clamping, fault checks, axis coordinate of cell and
// source), then three stages of the index pipeline (row product, plane product, final sum);
// the last of these is the output register. The whole pipeline holds while the output beat
// waits, so input ready follows output ready in that case. Configuration writes are taken
// at once and must be made only while the pipeline is empty.

module ghost_cell_boundary_source (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gcbs_cfg_if.sink    cfg_i,
  gcbs_in_if.sink     in_i,
  gcbs_out_if.source  out_o
);

  localparam int AW    = gcbs_pkg::AW;
  localparam int EXT_W = gcbs_pkg::EXT_W;

  logic [gcbs_pkg::EXT_REG_W-1:0] ext_x_q, ext_y_q, ext_z_q;
  logic [gcbs_pkg::GH_REG_W-1:0]  gh_x_q, gh_y_q, gh_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_x_q <= gcbs_pkg::EXT_REG_W'(1);
      ext_y_q <= gcbs_pkg::EXT_REG_W'(1);
      ext_z_q <= gcbs_pkg::EXT_REG_W'(1);
      gh_x_q  <= '0;
      gh_y_q  <= '0;
      gh_z_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gcbs_pkg::CFG_EXTENT_X: ext_x_q <= cfg_i.data;
        gcbs_pkg::CFG_EXTENT_Y: ext_y_q <= cfg_i.data;
        gcbs_pkg::CFG_EXTENT_Z: ext_z_q <= cfg_i.data;
        gcbs_pkg::CFG_GHOST_X:  gh_x_q  <= gcbs_pkg::GH_REG_W'(cfg_i.data);
        gcbs_pkg::CFG_GHOST_Y:  gh_y_q  <= gcbs_pkg::GH_REG_W'(cfg_i.data);
        gcbs_pkg::CFG_GHOST_Z:  gh_z_q  <= gcbs_pkg::GH_REG_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // clamped geometry
  logic [AW-1:0] ext_x, ext_y, ext_z, gh_x, gh_y, gh_z;

  always_comb begin
    ext_x = (ext_x_q == '0) ? AW'(1) :
            (32'(ext_x_q) > 32'(gcbs_pkg::MAX_EXTENT)) ? AW'(gcbs_pkg::MAX_EXTENT) : AW'(ext_x_q);
    ext_y = (ext_y_q == '0) ? AW'(1) :
            (32'(ext_y_q) > 32'(gcbs_pkg::MAX_EXTENT)) ? AW'(gcbs_pkg::MAX_EXTENT) : AW'(ext_y_q);
    ext_z = (ext_z_q == '0) ? AW'(1) :
            (32'(ext_z_q) > 32'(gcbs_pkg::MAX_EXTENT)) ? AW'(gcbs_pkg::MAX_EXTENT) : AW'(ext_z_q);
    gh_x  = (32'(gh_x_q) > 32'(gcbs_pkg::MAX_GHOST)) ? AW'(gcbs_pkg::MAX_GHOST) : AW'(gh_x_q);
    gh_y  = (32'(gh_y_q) > 32'(gcbs_pkg::MAX_GHOST)) ? AW'(gcbs_pkg::MAX_GHOST) : AW'(gh_y_q);
    gh_z  = (32'(gh_z_q) > 32'(gcbs_pkg::MAX_GHOST)) ? AW'(gcbs_pkg::MAX_GHOST) : AW'(gh_z_q);
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, en;
  assign en         = !v4_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // decode stage
  logic [AW-1:0] n, g, ext_ta, ext_tb, lay, ca, cb;
  logic [AW-1:0] e, span, p, sp;
  logic          bad_axis, bad_kind, flt;
  gcbs_pkg::flags_t flags_d;
  logic [EXT_W-1:0] cx_d, cy_d, cz_d, sx_d, sy_d, sz_d;

  always_comb begin
    bad_axis = 1'b0;
    n        = ext_x;
    g        = gh_x;
    ext_ta   = ext_y;
    ext_tb   = ext_z;
    case (in_i.axis)
      gcbs_pkg::AXIS_X: begin
        n = ext_x; g = gh_x; ext_ta = ext_y; ext_tb = ext_z;
      end
      gcbs_pkg::AXIS_Y: begin
        n = ext_y; g = gh_y; ext_ta = ext_x; ext_tb = ext_z;
      end
      gcbs_pkg::AXIS_Z: begin
        n = ext_z; g = gh_z; ext_ta = ext_x; ext_tb = ext_y;
      end
      default: bad_axis = 1'b1;
    endcase

    lay  = AW'(in_i.layer);
    ca   = AW'(in_i.coord_a);
    cb   = AW'(in_i.coord_b);
    e    = n - g - AW'(1);
    span = n - (g << 1);
    p    = in_i.side ? (e + AW'(1) + lay) : (g - AW'(1) - lay);

    bad_kind        = 1'b0;
    sp              = '0;
    flags_d         = '0;
    case (in_i.boundary_kind)
      gcbs_pkg::KIND_REFLECT: begin
        sp = in_i.side ? (e - lay) : (g + lay);
        flags_d.negate = in_i.normal_velocity;
      end
      gcbs_pkg::KIND_OUTFLOW:  sp = in_i.side ? e : g;
      gcbs_pkg::KIND_INFLOW:   flags_d.use_inflow = 1'b1;
      gcbs_pkg::KIND_PERIODIC: sp = in_i.side ? (p - span) : (p + span);
      default: bad_kind = 1'b1;
    endcase

    flt = bad_axis || bad_kind || (lay >= g) || (n <= (g << 1)) ||
          (ca >= ext_ta) || (cb >= ext_tb);
    if (flt) begin
      flags_d = '0;
      flags_d.fault = 1'b1;
    end

    // zero coordinates give zero indexes for faulted beats and a zero source index for inflow beats
    cx_d = '0; cy_d = '0; cz_d = '0;
    sx_d = '0; sy_d = '0; sz_d = '0;
    if (!flt) begin
      case (in_i.axis)
        gcbs_pkg::AXIS_X: begin
          cx_d = EXT_W'(p);  cy_d = EXT_W'(ca); cz_d = EXT_W'(cb);
          sx_d = EXT_W'(sp); sy_d = EXT_W'(ca); sz_d = EXT_W'(cb);
        end
        gcbs_pkg::AXIS_Y: begin
          cx_d = EXT_W'(ca); cy_d = EXT_W'(p);  cz_d = EXT_W'(cb);
          sx_d = EXT_W'(ca); sy_d = EXT_W'(sp); sz_d = EXT_W'(cb);
        end
        default: begin
          cx_d = EXT_W'(ca); cy_d = EXT_W'(cb); cz_d = EXT_W'(p);
          sx_d = EXT_W'(ca); sy_d = EXT_W'(cb); sz_d = EXT_W'(sp);
        end
      endcase
      if (flags_d.use_inflow) begin
        sx_d = '0; sy_d = '0; sz_d = '0;
      end
    end
  end

  logic [EXT_W-1:0] cx1_q, cy1_q, cz1_q, sx1_q, sy1_q, sz1_q;
  gcbs_pkg::flags_t f1_q, f2_q, f3_q, f4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q <= cx_d; cy1_q <= cy_d; cz1_q <= cz_d;
      sx1_q <= sx_d; sy1_q <= sy_d; sz1_q <= sz_d;
      f1_q  <= flags_d;
      f2_q  <= f1_q;
      f3_q  <= f2_q;
      f4_q  <= f3_q;
    end
  end

  logic [gcbs_pkg::IDX_W-1:0] tgt_idx, src_idx;

  gcbs_lin_index u_tgt_index (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (cx1_q),
    .y_i     (cy1_q),
    .z_i     (cz1_q),
    .ext_x_i (EXT_W'(ext_x)),
    .ext_y_i (EXT_W'(ext_y)),
    .idx_o   (tgt_idx)
  );

  gcbs_lin_index u_src_index (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (sx1_q),
    .y_i     (sy1_q),
    .z_i     (sz1_q),
    .ext_x_i (EXT_W'(ext_x)),
    .ext_y_i (EXT_W'(ext_y)),
    .idx_o   (src_idx)
  );

  assign out_o.valid        = v4_q;
  assign out_o.target_index = tgt_idx;
  assign out_o.source_index = src_idx;
  assign out_o.negate       = f4_q.negate;
  assign out_o.use_inflow   = f4_q.use_inflow;
  assign out_o.fault        = f4_q.fault;

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.fault) |-> (out_o.target_index == '0 &&
      out_o.source_index == '0 && !out_o.negate && !out_o.use_inflow))
    else $error("faulted beat carries nonzero fields");

  a_inflow_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.use_inflow) |-> (out_o.source_index == '0 && !out_o.negate))
    else $error("inflow beat with source index or negate");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && !out_o.ready) |=> (v3_q && v4_q))
    else $error("pipeline dropped a beat during stall");

endmodule

`default_nettype wire
